// ----- src/q2r_pkg.sv -----
// Shared constants and types for the quaternion to rotation matrix block.
`default_nettype none
package q2r_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int FIELD_W = 16;
  localparam int NUM_LANES = 9;
  localparam int NUM_PROD = 10;
  localparam int N2_W = 33;
  localparam int MAG_W = 33;
  localparam int NUM_W = 34;
  // Lanes 0, 4 and 8 carry the diagonal entries.
  localparam logic [NUM_LANES-1:0] DIAG_LANES = 9'b1_0001_0001;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [31:0] prod_t;
  typedef logic [N2_W-1:0] norm2_t;
  typedef logic [MAG_W-1:0] mag_t;
endpackage
`default_nettype wire

// ----- src/q2r_if.sv -----
// Valid/ready channel interfaces for quaternion beats and matrix beats.
`default_nettype none
interface q2r_in_if;
  import q2r_pkg::*;
  logic   valid;
  logic   ready;
  field_t quat_x;
  field_t quat_y;
  field_t quat_z;
  field_t quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2r_out_if;
  import q2r_pkg::*;
  logic   valid;
  logic   ready;
  field_t rot_00;
  field_t rot_01;
  field_t rot_02;
  field_t rot_10;
  field_t rot_11;
  field_t rot_12;
  field_t rot_20;
  field_t rot_21;
  field_t rot_22;
  logic   zero_length;
  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, zero_length, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, zero_length, output ready);
endinterface
`default_nettype wire

// ----- src/quaternion_to_rotation_matrix.sv -----
// Top level: pipelined quaternion to normalized rotation matrix converter.
//
// A quaternion beat (x, y, z, w, signed with FRAC_BITS fraction bits) enters on
// in_ch; one matrix beat with the nine entries and a zero-length flag leaves on
// out_ch. Both channels use valid/ready; a beat moves when both are high.
// The first stage forms the ten component products, the second the squared
// norm and the nine signed numerators. Then a restoring divider, one quotient
// bit per stage across all nine lanes, runs FRAC_BITS+3 stages. A last stage
// rounds to nearest (ties away from zero), forms one minus the quotient on the
// diagonal, clamps to plus or minus one and registers the result.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the per-bit divider stages, which each take a new item.
// When the receiver stalls with a result waiting, the whole pipeline holds:
// in_ch.ready drops and nothing is lost or repeated. As soon as the waiting
// beat is taken the pipeline moves again in the same cycle.
// A quaternion of all zeros gives zero_length set and a zero matrix.
// Synchronous reset clears every valid bit; the data registers are not reset.
`default_nettype none
module quaternion_to_rotation_matrix
  import q2r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  q2r_in_if.sink    in_ch,
  q2r_out_if.source out_ch
);
  // Quotient bits before rounding: two integer bits and FRAC_BITS+1 fraction.
  localparam int QB = FRAC_BITS + 3;
  localparam int RW = MAG_W + 2;
  localparam int VW = (QB + 1 > FIELD_W + 1) ? QB + 1 : FIELD_W + 1;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: products.
  logic  a_vld_r;
  prod_t prod_r [NUM_PROD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= in_ch.quat_x * in_ch.quat_x;
      prod_r[1] <= in_ch.quat_y * in_ch.quat_y;
      prod_r[2] <= in_ch.quat_z * in_ch.quat_z;
      prod_r[3] <= in_ch.quat_w * in_ch.quat_w;
      prod_r[4] <= in_ch.quat_x * in_ch.quat_y;
      prod_r[5] <= in_ch.quat_x * in_ch.quat_z;
      prod_r[6] <= in_ch.quat_y * in_ch.quat_z;
      prod_r[7] <= in_ch.quat_w * in_ch.quat_x;
      prod_r[8] <= in_ch.quat_w * in_ch.quat_y;
      prod_r[9] <= in_ch.quat_w * in_ch.quat_z;
    end
  end

  // Stage B: norm and numerators. Index 0 of the divider arrays is its input.
  logic                  vld_r  [QB+1];
  logic                  zero_r [QB+1];
  norm2_t                n2_r   [QB+1];
  logic [RW-1:0]         rem_r  [QB+1][NUM_LANES];
  logic [QB-1:0]         q_r    [QB+1][NUM_LANES];
  logic [NUM_LANES-1:0]  neg_r  [QB+1];

  logic signed [NUM_W-1:0] pe [NUM_PROD];
  logic signed [NUM_W-1:0] num [NUM_LANES];
  norm2_t                  n2_nxt;

  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      pe[i] = NUM_W'(prod_r[i]);
    end
    n2_nxt = N2_W'(pe[0] + pe[1] + pe[2] + pe[3]);
    num[0] = (pe[1] + pe[2]) <<< 1;
    num[1] = (pe[4] - pe[9]) <<< 1;
    num[2] = (pe[5] + pe[8]) <<< 1;
    num[3] = (pe[4] + pe[9]) <<< 1;
    num[4] = (pe[0] + pe[2]) <<< 1;
    num[5] = (pe[6] - pe[7]) <<< 1;
    num[6] = (pe[5] - pe[8]) <<< 1;
    num[7] = (pe[6] + pe[7]) <<< 1;
    num[8] = (pe[0] + pe[1]) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r[0]   <= n2_nxt;
      zero_r[0] <= (n2_nxt == '0);
      for (int l = 0; l < NUM_LANES; l++) begin
        neg_r[0][l] <= num[l][NUM_W-1];
        rem_r[0][l] <= RW'(num[l][NUM_W-1] ? -num[l] : num[l]);
        q_r[0][l]   <= '0;
      end
    end
  end

  // Divider stages: stage s settles quotient bit QB-1-s.
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    logic [RW-1:0] rsh  [NUM_LANES];
    logic [RW-1:0] dcmp;
    logic [NUM_LANES-1:0] ge;

    always_comb begin
      if (K > FRAC_BITS) begin
        dcmp = RW'(n2_r[s]) << (K - FRAC_BITS - 1);
      end else begin
        dcmp = RW'(n2_r[s]);
      end
      for (int l = 0; l < NUM_LANES; l++) begin
        rsh[l] = (K > FRAC_BITS) ? rem_r[s][l] : (rem_r[s][l] << 1);
        ge[l]  = (rsh[l] >= dcmp);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n2_r[s+1]   <= n2_r[s];
        zero_r[s+1] <= zero_r[s];
        neg_r[s+1]  <= neg_r[s];
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_r[s+1][l] <= ge[l] ? rsh[l] - dcmp : rsh[l];
          q_r[s+1][l]   <= q_r[s][l] | (QB'(ge[l]) << K);
        end
      end
    end
  end

  // Final stage: round, diagonal, clamp, zero case.
  logic signed [VW-1:0] one_v;
  logic signed [VW-1:0] rnd  [NUM_LANES];
  logic signed [VW-1:0] val  [NUM_LANES];
  field_t               ent_nxt [NUM_LANES];

  always_comb begin
    one_v = VW'(1) <<< FRAC_BITS;
    for (int l = 0; l < NUM_LANES; l++) begin
      rnd[l] = (VW'(q_r[QB][l]) + VW'(1)) >>> 1;
      if (DIAG_LANES[l]) begin
        val[l] = one_v - rnd[l];
      end else begin
        val[l] = neg_r[QB][l] ? -rnd[l] : rnd[l];
      end
      if (val[l] > one_v) begin
        val[l] = one_v;
      end else if (val[l] < -one_v) begin
        val[l] = -one_v;
      end
      ent_nxt[l] = zero_r[QB] ? '0 : val[l][FIELD_W-1:0];
    end
  end

  logic   out_vld_r;
  logic   zero_out_r;
  field_t rot_r [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_out_r <= zero_r[QB];
      for (int l = 0; l < NUM_LANES; l++) begin
        rot_r[l] <= ent_nxt[l];
      end
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.zero_length = zero_out_r;
  assign out_ch.rot_00      = rot_r[0];
  assign out_ch.rot_01      = rot_r[1];
  assign out_ch.rot_02      = rot_r[2];
  assign out_ch.rot_10      = rot_r[3];
  assign out_ch.rot_11      = rot_r[4];
  assign out_ch.rot_12      = rot_r[5];
  assign out_ch.rot_20      = rot_r[6];
  assign out_ch.rot_21      = rot_r[7];
  assign out_ch.rot_22      = rot_r[8];

  // A zero-length result carries zeros on the diagonal and in rot_r[1] and rot_r[5].
  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && zero_out_r |-> (rot_r[0] == '0) && (rot_r[4] == '0) &&
      (rot_r[8] == '0) && (rot_r[1] == '0) && (rot_r[5] == '0))
    else $error("zero-length beat with nonzero matrix");

  // Stage B flags zero exactly when the norm is zero.
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (zero_r[0] == (n2_r[0] == '0)))
    else $error("zero flag disagrees with norm");

  // A beat waiting at the output freezes the last divider stage.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(vld_r[QB]) && $stable(zero_r[QB]))
    else $error("pipeline moved during a stall");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_vld_r && !vld_r[0])
    else $error("valid bits survive reset");
endmodule
`default_nettype wire

// ----- dv/tb_quaternion_to_rotation_matrix.sv -----
// Self-checking testbench for the quaternion to rotation matrix converter.
`default_nettype none
module tb_quaternion_to_rotation_matrix;
  import q2r_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = FB + 6;
  localparam longint CYCLE_LIMIT = 400000;

  // One predicted matrix beat: nine entries in row-major order plus the flag.
  typedef struct {
    field_t ent [9];
    logic   zero_len;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  q2r_in_if  in_ch ();
  q2r_out_if out_ch ();

  quaternion_to_rotation_matrix #(.FRAC_BITS(FB)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  matrix_t expected_mats[$];
  int      n_sent;
  int      n_checked;
  int      n_zero;
  int      n_errors;
  int      rx_wait;
  longint  cycle_cnt = 0;

  // Rounded quotient num * 2^FB / den, ties away from zero; den is positive.
  function automatic longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * (mag <<< FB) + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // Clamps to plus or minus one and keeps the low field bits.
  function automatic field_t to_entry(longint v);
    longint one;
    one = longint'(1) <<< FB;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return field_t'(v[FIELD_W-1:0]);
  endfunction

  // Rotation matrix of the normalized quaternion, each entry rounded once.
  function automatic matrix_t rotation_of(field_t qx, field_t qy, field_t qz, field_t qw);
    matrix_t m;
    longint x, y, z, w, xx, yy, zz, n2, one;
    x = qx; y = qy; z = qz; w = qw;
    xx = x * x; yy = y * y; zz = z * z;
    n2 = xx + yy + zz + w * w;
    one = longint'(1) <<< FB;
    m.zero_len = (n2 == 0);
    if (n2 == 0) begin
      foreach (m.ent[k]) m.ent[k] = '0;
      return m;
    end
    m.ent[0] = to_entry(one - round_quot(2 * (yy + zz), n2));
    m.ent[1] = to_entry(round_quot(2 * (x * y - w * z), n2));
    m.ent[2] = to_entry(round_quot(2 * (x * z + w * y), n2));
    m.ent[3] = to_entry(round_quot(2 * (x * y + w * z), n2));
    m.ent[4] = to_entry(one - round_quot(2 * (xx + zz), n2));
    m.ent[5] = to_entry(round_quot(2 * (y * z - w * x), n2));
    m.ent[6] = to_entry(round_quot(2 * (x * z - w * y), n2));
    m.ent[7] = to_entry(round_quot(2 * (y * z + w * x), n2));
    m.ent[8] = to_entry(one - round_quot(2 * (xx + yy), n2));
    return m;
  endfunction

  // Sends one quaternion beat after a random gap, unless no_gap is set, and records its prediction.
  // Valid stays high after the beat so that a following beat with no gap
  // goes out back to back; a gap or a drain lowers it.
  task automatic send_quat(field_t qx, field_t qy, field_t qz, field_t qw, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_x <= qx;
    in_ch.quat_y <= qy;
    in_ch.quat_z <= qz;
    in_ch.quat_w <= qw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The beat moved at this edge; the prediction goes in before the result can arrive.
    expected_mats.push_back(rotation_of(qx, qy, qz, qw));
    n_sent++;
    if (qx == 0 && qy == 0 && qz == 0 && qw == 0) n_zero++;
  endtask

  task automatic test_directed();
    field_t ext [6];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff, 16'sh4000};
    send_quat(0, 0, 0, 0);                         // zero length
    send_quat(0, 0, 0, 16'sh4000);                 // identity
    send_quat(16'sh4000, 0, 0, 0);                 // half turns about each axis
    send_quat(0, 16'sh4000, 0, 0);
    send_quat(0, 0, 16'sh4000, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(0, 0, 0, 16'sh0001);                 // tiny but nonzero length
    send_quat(16'sh0001, 16'shffff, 16'sh0001, 16'shffff);
    send_quat(16'sh2d41, 0, 0, 16'sh2d41);         // quarter turn
    for (int k = 0; k < 12; k++)
      send_quat(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]);
  endtask

  task automatic test_random(int count);
    field_t c [4];
    for (int k = 0; k < count; k++) begin
      foreach (c[j]) begin
        case ($urandom_range(0, 9))
          0:       c[j] = '0;
          1:       c[j] = field_t'($urandom_range(0, 3) - 1);
          2:       c[j] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
          default: c[j] = field_t'($urandom);
        endcase
      end
      if ($urandom_range(0, 49) == 0) c = '{0, 0, 0, 0};
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  // Back-to-back burst so the pipeline fills while the receiver stalls at random.
  task automatic test_burst(int count);
    for (int k = 0; k < count; k++)
      send_quat(field_t'($urandom), field_t'($urandom), field_t'($urandom),
                field_t'($urandom), 1'b1);
  endtask

  // The sender holds off until every outstanding matrix has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
  endtask

  // Receiver: draws a random wait after every beat it takes, with stall-free
  // stretches in between.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = ((cycle_cnt / 2000) % 3 == 2) ? 0 : $urandom_range(0, 8);
      rx_wait      <= w;
      out_ch.ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker: every accepted matrix beat against the oldest prediction.
  always @(posedge clk) begin
    matrix_t exp_m;
    field_t  act [9];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act = '{out_ch.rot_00, out_ch.rot_01, out_ch.rot_02, out_ch.rot_10,
              out_ch.rot_11, out_ch.rot_12, out_ch.rot_20, out_ch.rot_21,
              out_ch.rot_22};
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected matrix beat, no prediction pending", $time);
        n_errors++;
      end else begin
        exp_m = expected_mats.pop_front();
        foreach (act[k])
          if (act[k] !== exp_m.ent[k]) begin
            $display("%0t: rot_%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     exp_m.ent[k], act[k]);
            n_errors++;
          end
        if (out_ch.zero_length !== exp_m.zero_len) begin
          $display("%0t: zero_length expected %0b actual %0b", $time,
                   exp_m.zero_len, out_ch.zero_length);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results pending", $time,
               expected_mats.size());
      $display("tb_quaternion_to_rotation_matrix: done, errors");
      $finish;
    end
  end

  initial begin
    n_sent       = 0;
    n_checked    = 0;
    n_zero       = 0;
    n_errors     = 0;
    in_ch.valid  = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_random(800);
    drain_results();
    test_burst(100);
    test_random(800);
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_mats.size() != 0) begin
      $display("%0t: %0d predictions never matched", $time, expected_mats.size());
      n_errors++;
    end

    $display("Converted %0d quaternions (%0d of zero length), %0d matrices checked.",
             n_sent, n_zero, n_checked);
    $display("Covered axis extremes, half and quarter turns, bursts and random stalls.");
    if (n_errors == 0) begin
      $display("tb_quaternion_to_rotation_matrix: done, clean");
    end else begin
      $display("tb_quaternion_to_rotation_matrix: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
